### sv/ctc_pkg.sv
package ctc_pkg;

    // opcodes
    localparam logic [1:0] OP_CMD    = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_KEY    = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // device numbers and units
    localparam logic [2:0] DEV_INPUT = 3'd2;
    localparam logic [2:0] DEV_MAX   = 3'd3;
    localparam logic       UNIT_OUT  = 1'b0;
    localparam logic       UNIT_IN   = 1'b1;

    // status bits
    localparam logic [13:0] ST_END    = 14'o000001;
    localparam logic [13:0] ST_BUSY   = 14'o000040;
    localparam logic [13:0] ST_INPUT  = 14'o000100;
    localparam logic [13:0] ST_CANCEL = 14'o000200;
    localparam logic [13:0] ST_ACCEPT = 14'o000400;
    localparam logic [13:0] ST_F1     = 14'o001000;

    // characters
    localparam logic [6:0] CH_NONE   = 7'o000;
    localparam logic [6:0] CH_BELL   = 7'o007;
    localparam logic [6:0] CH_LF     = 7'o012;
    localparam logic [6:0] CH_CR     = 7'o015;
    localparam logic [6:0] CH_ETX    = 7'o003;
    localparam logic [6:0] CH_NAK    = 7'o025;
    localparam logic [6:0] CH_CAN    = 7'o030;
    localparam logic [6:0] CH_ESC    = 7'o033;
    localparam logic [6:0] CH_ONE    = 7'o061;
    localparam logic [6:0] CH_FIVE   = 7'o065;
    localparam logic [6:0] CODE_CRLF = 7'o137;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] unit_select;
        logic [1:0] cmd_bits;
        logic [7:0] key_code;
        logic [5:0] chan_code;
        logic       chan_end;
        logic       term_ready;
    } ctc_in_t;

    typedef struct packed {
        logic [13:0] status_word;
        logic [6:0]  term_char;
        logic        term_valid;
        logic [5:0]  chan_code_out;
        logic        chan_code_valid;
        logic        done_set;
        logic        done_clear;
        logic        done_unit;
        logic        last;
    } ctc_out_t;

    function automatic logic [6:0] code_to_ascii(input logic [5:0] c);
        logic [6:0] r;
        case (c[5:4])
            2'd0:    r = {3'b011, c[3:0]};
            2'd1:    r = {3'b010, c[3:0]};
            2'd2:    r = {3'b100, c[3:0]};
            default: r = {3'b101, c[3:0]};
        endcase
        return r;
    endfunction

endpackage

### sv/console_terminal_controller.sv
// An accepted word is registered in in_reg and decoded in the following cycle; its first
// result word enters the result queue when the queue has room, and m_valid shows it.
// Throughput: one input word per cycle while the result queue has room; a line-accept
// key echoes CR and LF as two words, as the result side moves one word per cycle.
// Reset (aresetn low, synchronous): all unit status, held character, reading and escape
// flags clear; words in flight are dropped.
module console_terminal_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ctc_pkg::ctc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ctc_pkg::ctc_out_t  m_data
);
    import ctc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    ctc_in_t     in_reg;

    logic [13:0] out_status_reg, out_status_next;
    logic [6:0]  out_held_reg, out_held_next;
    logic [13:0] in_status_reg, in_status_next;
    logic        in_reading_reg, in_reading_next;
    logic        in_esc_reg, in_esc_next;

    ctc_out_t    q_reg [2];
    ctc_out_t    q_next [2];
    logic [1:0]  cnt_reg, cnt_next;

    ctc_out_t    r0, r1;
    logic [1:0]  nres;
    logic        pop, advance;
    logic [1:0]  cnt_pop;
    logic [2:0]  cnt_sum;

    // decode of the registered word
    always_comb begin
        logic [13:0] st;
        logic        unit;
        logic [6:0]  ch;
        logic [6:0]  m;
        logic [6:0]  c;
        logic [2:0]  fidx;

        out_status_next = out_status_reg;
        out_held_next   = out_held_reg;
        in_status_next  = in_status_reg;
        in_reading_next = in_reading_reg;
        in_esc_next     = in_esc_reg;
        r0   = '0;
        r1   = '0;
        nres = 2'd0;
        unit = (in_reg.unit_select == DEV_INPUT) ? UNIT_IN : UNIT_OUT;
        st   = unit ? in_status_reg : out_status_reg;
        ch   = in_reg.key_code[6:0];
        m    = ch;
        c    = code_to_ascii(in_reg.chan_code);
        fidx = 3'(ch - CH_ONE);

        unique case (in_reg.opcode)
            OP_CMD, OP_STATUS: begin
                if (in_reg.unit_select <= DEV_MAX) begin
                    r0.done_clear = 1'b1;
                    r0.done_unit  = unit;
                    nres = 2'd1;
                    if (in_reg.opcode == OP_CMD) begin
                        if (in_reg.cmd_bits[0]) begin
                            st = ST_BUSY;
                            if (unit) in_reading_next = 1'b1;
                        end
                        if (in_reg.cmd_bits[1]) st = st & ~ST_BUSY;
                    end else begin
                        r0.status_word = st;
                        st = st & ST_BUSY;
                    end
                    if (unit) in_status_next = st;
                    else      out_status_next = st;
                end
            end
            OP_KEY: begin
                r0.done_unit = UNIT_IN;
                nres = 2'd1;
                if (in_esc_reg) begin
                    in_esc_next = 1'b0;
                    if (ch >= CH_ONE && ch <= CH_FIVE) begin
                        in_status_next  = in_status_reg | 14'(ST_F1 << fidx);
                        in_reading_next = 1'b0;
                        r0.done_set     = 1'b1;
                    end else begin
                        r0.term_valid = 1'b1;
                        r0.term_char  = CH_BELL;
                    end
                end else if (ch == CH_ESC) begin
                    in_esc_next = 1'b1;
                    nres = 2'd0;
                end else if (ch == CH_CAN) begin
                    in_status_next  = in_status_reg | ST_INPUT;
                    in_reading_next = 1'b0;
                    r0.done_set     = 1'b1;
                end else if (ch == CH_ETX || ch == CH_NAK) begin
                    in_status_next  = in_status_reg | ST_CANCEL;
                    in_reading_next = 1'b0;
                    r0.done_set     = 1'b1;
                end else if (!in_reading_reg) begin
                    r0.term_valid = 1'b1;
                    r0.term_char  = CH_BELL;
                end else if (ch == CH_CR || ch == CH_LF) begin
                    in_status_next  = in_status_reg | ST_ACCEPT;
                    in_reading_next = 1'b0;
                    r0.term_valid   = 1'b1;
                    r0.term_char    = CH_CR;
                    r1.term_valid   = 1'b1;
                    r1.term_char    = CH_LF;
                    r1.done_set     = 1'b1;
                    r1.done_unit    = UNIT_IN;
                    nres = 2'd2;
                end else begin
                    if (m >= 7'o140) m = m - 7'o040;
                    if (m >= 7'o100)      m = m - 7'o040;
                    else if (m >= 7'o060) m = m - 7'o060;
                    else if (m >= 7'o040) m = m - 7'o020;
                    else                  m = CH_NONE;
                    r0.term_valid = 1'b1;
                    if (ch < 7'o040) begin
                        // control character with no meaning here
                        r0.term_char = CH_BELL;
                    end else begin
                        r0.term_char       = code_to_ascii(m[5:0]);
                        r0.chan_code_out   = m[5:0];
                        r0.chan_code_valid = 1'b1;
                        r0.done_set        = in_reg.chan_end;
                        if (in_reg.chan_end) begin
                            in_reading_next = 1'b0;
                            in_status_next  = in_status_reg | ST_ACCEPT | ST_END;
                        end
                    end
                end
            end
            OP_TICK: begin
                r0.done_unit = UNIT_OUT;
                if (out_held_reg != CH_NONE) begin
                    if (in_reg.term_ready) begin
                        out_held_next = (out_held_reg == CH_CR) ? CH_LF : CH_NONE;
                        r0.term_valid = 1'b1;
                        r0.term_char  = out_held_reg;
                        nres = 2'd1;
                    end
                end else if ((out_status_reg & ST_BUSY) != '0) begin
                    if (c == CODE_CRLF) begin
                        c = CH_CR;
                        out_held_next = CH_LF;
                    end
                    if (!in_reg.term_ready) out_held_next = c;
                    if (in_reg.chan_end)
                        out_status_next = (out_status_reg & ~ST_BUSY) | ST_END;
                    if (in_reg.term_ready || in_reg.chan_end) begin
                        r0.term_valid = in_reg.term_ready;
                        r0.term_char  = in_reg.term_ready ? c : CH_NONE;
                        r0.done_set   = in_reg.chan_end;
                        nres = 2'd1;
                    end
                end
            end
            default: ;
        endcase
        r0.last = (nres == 2'd1);
        r1.last = 1'b1;
    end

    // result queue, head at entry 0
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q_reg[0];
    assign pop     = m_valid && m_ready;
    assign cnt_pop = cnt_reg - {1'b0, pop};
    assign cnt_sum = {1'b0, cnt_pop} + {1'b0, nres};
    assign advance = in_valid_reg && (cnt_sum <= 3'd2);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        q_next   = q_reg;
        cnt_next = cnt_pop;
        if (pop) q_next[0] = q_reg[1];
        if (advance) begin
            if (nres != 2'd0) q_next[cnt_pop[0]] = r0;
            if (nres == 2'd2) q_next[1] = r1;
            cnt_next = cnt_sum[1:0];
        end
        if (s_valid && s_ready) in_valid_next = 1'b1;
        else if (advance)       in_valid_next = 1'b0;
        else                    in_valid_next = in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        if (s_valid && s_ready) in_reg <= s_data;
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cnt_reg        <= 2'd0;
            out_status_reg <= '0;
            out_held_reg   <= CH_NONE;
            in_status_reg  <= '0;
            in_reading_reg <= 1'b0;
            in_esc_reg     <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (advance) begin
                out_status_reg <= out_status_next;
                out_held_reg   <= out_held_next;
                in_status_reg  <= in_status_next;
                in_reading_reg <= in_reading_next;
                in_esc_reg     <= in_esc_next;
            end
        end
    end

endmodule

### sv/ctc_checker.sv
module ctc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input ctc_pkg::ctc_out_t  m_data
);
    import ctc_pkg::*;

    // a stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.term_valid |-> m_data.term_char == CH_NONE)
        else $error("terminal char without valid");

    a_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.chan_code_valid |-> m_data.chan_code_out == 6'd0)
        else $error("channel code without valid");

    // status only comes back on a status read, which clears done
    a_status_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status_word != 14'd0 |->
            m_data.done_clear && !m_data.done_set && !m_data.term_valid)
        else $error("status word outside a status read");

    // echoed CR of a line accept is followed by its LF
    a_crlf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && m_data.last && m_data.term_char == CH_LF)
        else $error("first of two words not followed by LF");

endmodule

bind console_terminal_controller ctc_checker u_ctc_checker (.*);
